// ===== rtl/bbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// shared constants, types and the reciprocal table of the 3x3 box blur
// ----------------------------------------------------------------------------
package bbe_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = COL_W + 1;
   localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 2);
   localparam int OROW_W = $clog2(HEIGHT_LIMIT);

   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int CH_W   = 8;
   localparam int PIX_W  = 3 * CH_W;
   localparam int SUM_W  = 12;
   localparam int CNT_W  = 4;
   localparam int NUM_W  = SUM_W + 1;
   localparam int RCP_K  = 20;
   localparam int RCP_W  = 20;
   localparam int PROD_W = NUM_W + RCP_W;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
   localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

   typedef struct packed {
      logic             take;
      logic             emit;
      logic             last;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic [COL_W-1:0] col;
   } ctl_type;

   // ceil(2^RCP_K / (2*count))
   function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RCP_W-1:0] r;
      case (cnt)
         4'd1:    r = RCP_W'(524288);
         4'd2:    r = RCP_W'(262144);
         4'd3:    r = RCP_W'(174763);
         4'd4:    r = RCP_W'(131072);
         4'd5:    r = RCP_W'(104858);
         4'd6:    r = RCP_W'(87382);
         4'd7:    r = RCP_W'(74899);
         4'd8:    r = RCP_W'(65536);
         4'd9:    r = RCP_W'(58255);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_normalized_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_top
// 3x3 box blur over an rgb raster stream, averaged over in-frame neighbors
// ----------------------------------------------------------------------------
// req_* takes items in raster order: tuser low is a pixel, tuser high a drain
// item. after the last pixel of a frame, width+1 drain items push out the
// remaining results; pixels past the frame and early drains are dropped.
// rsp_* gives one blurred pixel per item that completes a neighborhood, one
// row plus one pixel behind the input; tlast marks the frame's last pixel.
// a result shows on rsp_tvalid once the item completing its neighborhood has
// passed stage 1, stage 2 and the output register. throughput: one item per
// clock unless rsp stalls, set by one line memory read and write per cycle.
// csr_*: width at 0x0, height at 0x4; a write restarts the frame.
// reset: width 640, height 480, positions cleared; line memory contents are
// not cleared and are never used before being written.
// a stalled receiver fills the output register, stage 2 and stage 1, then req_tready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bbe_pkg::PIX_W-1:0]   req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic                        req_tuser,   // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bbe_pkg::PIX_W-1:0]   rsp_tdata,   // blur_red, blur_green, blur_blue
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bbe_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [bbe_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [bbe_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int CW = bbe_pkg::CH_W;
   localparam int PW = bbe_pkg::PIX_W;

   // configuration
   logic [bbe_pkg::FW_W-1:0]  frame_width_ff;
   logic [bbe_pkg::FH_W-1:0]  frame_height_ff;
   logic                      csr_wr;
   logic [bbe_pkg::WID_W-1:0] eff_w;
   logic [bbe_pkg::ROW_W-1:0] eff_h;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bbe_pkg::WIDTH_RESET;
         frame_height_ff <= bbe_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            bbe_pkg::REG_WIDTH:  frame_width_ff  <= csr_pwdata[bbe_pkg::FW_W-1:0];
            bbe_pkg::REG_HEIGHT: frame_height_ff <= csr_pwdata[bbe_pkg::FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         bbe_pkg::REG_WIDTH:  csr_prdata = bbe_pkg::CSR_DW'(frame_width_ff);
         bbe_pkg::REG_HEIGHT: csr_prdata = bbe_pkg::CSR_DW'(frame_height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = bbe_pkg::WID_W'(1);
      end else if (int'(frame_width_ff) > bbe_pkg::MAX_WIDTH) begin
         eff_w = bbe_pkg::WID_W'(bbe_pkg::MAX_WIDTH);
      end else begin
         eff_w = bbe_pkg::WID_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = bbe_pkg::ROW_W'(1);
      end else if (int'(frame_height_ff) > bbe_pkg::HEIGHT_LIMIT) begin
         eff_h = bbe_pkg::ROW_W'(bbe_pkg::HEIGHT_LIMIT);
      end else begin
         eff_h = bbe_pkg::ROW_W'(frame_height_ff);
      end
   end

   // position tracking
   bbe_pkg::ctl_type ctl;
   logic             req_acc;
   logic             load;
   logic [PW-1:0]    req_pix;

   assign req_acc = req_tvalid && req_tready;
   assign load    = req_acc && ctl.take;
   assign req_pix = (req_tuser == bbe_pkg::KIND_DRAIN) ? '0
                  : {req_tdata[CW-1:0], req_tdata[2*CW-1:CW], req_tdata[3*CW-1:2*CW]};

   bbe_pos u_pos (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr),
      .step    (req_acc),
      .kind    (req_tuser),
      .eff_w   (eff_w),
      .eff_h   (eff_h),
      .ctl     (ctl)
   );

   // handshake between stages
   logic p1_valid_ff, p1_valid_in;
   logic p2_valid_ff, p2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, p2_ready, p1_adv, out_load;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign p2_ready   = !p2_valid_ff || out_ready;
   assign p1_adv     = p1_valid_ff && p2_ready;
   assign out_load   = p2_valid_ff && out_ready;
   assign req_tready = !p1_valid_ff || p2_ready;

   // stage 1: line memory read returns, window shift, write back
   logic                      p1_emit_ff, p1_last_ff;
   logic                      p1_top_ff, p1_bot_ff, p1_left_ff, p1_right_ff;
   logic [bbe_pkg::COL_W-1:0] p1_col_ff;
   logic [PW-1:0]             p1_pix_ff;
   logic                      fwd_hit_ff, fwd_hit_in;
   logic [2*PW-1:0]           fwd_data_ff;
   logic [2*PW-1:0]           ram_rdata, ram_wdata, col_old;

   assign col_old    = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign ram_wdata  = {col_old[PW-1:0], p1_pix_ff};
   assign fwd_hit_in = p1_adv && (p1_col_ff == ctl.col);

   bbe_ram #(
      .DATA_W (2 * PW),
      .DEPTH  (bbe_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (p1_adv),
      .waddr (p1_col_ff),
      .wdata (ram_wdata),
      .re    (load),
      .raddr (ctl.col),
      .rdata (ram_rdata)
   );

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (load) begin
         p1_valid_in = 1'b1;
      end else if (p1_adv) begin
         p1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p1_emit_ff  <= ctl.emit;
         p1_last_ff  <= ctl.last;
         p1_top_ff   <= ctl.top_ok;
         p1_bot_ff   <= ctl.bot_ok;
         p1_left_ff  <= ctl.left_ok;
         p1_right_ff <= ctl.right_ok;
         p1_col_ff   <= ctl.col;
         p1_pix_ff   <= req_pix;
         fwd_data_ff <= ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (load) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   logic [PW-1:0]             win_ff [9];
   logic [PW-1:0]             win_in [9];
   logic [2:0]                row_ok, col_ok;
   logic [bbe_pkg::SUM_W-1:0] sum_c [3];
   logic [bbe_pkg::CNT_W-1:0] cnt_c;

   assign row_ok = {p1_bot_ff, 1'b1, p1_top_ff};
   assign col_ok = {p1_right_ff, 1'b1, p1_left_ff};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = col_old[2*PW-1:PW];
      win_in[5] = col_old[PW-1:0];
      win_in[8] = p1_pix_ff;
      cnt_c = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sum_c[ch] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (row_ok[r] && col_ok[k]) begin
               cnt_c = cnt_c + bbe_pkg::CNT_W'(1);
               for (int ch = 0; ch < 3; ch++) begin
                  sum_c[ch] = sum_c[ch]
                            + bbe_pkg::SUM_W'(win_in[r*3 + k][CW*(2-ch) +: CW]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_adv) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // stage 2: channel sums and neighbor count
   logic [bbe_pkg::SUM_W-1:0] p2_sum_ff [3];
   logic [bbe_pkg::CNT_W-1:0] p2_cnt_ff;
   logic                      p2_last_ff;

   always_comb begin
      p2_valid_in = p2_valid_ff;
      if (p1_adv) begin
         p2_valid_in = p1_emit_ff;
      end else if (out_ready) begin
         p2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_adv) begin
         for (int ch = 0; ch < 3; ch++) begin
            p2_sum_ff[ch] <= sum_c[ch];
         end
         p2_cnt_ff  <= cnt_c;
         p2_last_ff <= p1_last_ff;
      end
   end

   // output: rounded average by reciprocal multiply
   logic [bbe_pkg::RCP_W-1:0]  rcp;
   logic [bbe_pkg::NUM_W-1:0]  num [3];
   logic [bbe_pkg::PROD_W-1:0] prod [3];
   logic [PW-1:0]              rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff;

   always_comb begin
      rcp = bbe_pkg::recip(p2_cnt_ff);
      for (int ch = 0; ch < 3; ch++) begin
         num[ch]  = {p2_sum_ff[ch], 1'b0} + bbe_pkg::NUM_W'(p2_cnt_ff);
         prod[ch] = bbe_pkg::PROD_W'(num[ch]) * bbe_pkg::PROD_W'(rcp);
         rsp_data_in[CW*ch +: CW] = prod[ch][bbe_pkg::RCP_K +: CW];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= p2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_fwd_only_column_zero: assert property (@(posedge clock) disable iff (reset)
      load && fwd_hit_in |-> ctl.col == '0)
      else $error("line memory forwarding away from column zero");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> (p2_cnt_ff >= bbe_pkg::CNT_W'(1)) && (p2_cnt_ff <= bbe_pkg::CNT_W'(9)))
      else $error("neighbor count out of range");

   a_p2_holds: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && !out_ready |=> p2_valid_ff && $stable(p2_cnt_ff) && $stable(p2_last_ff))
      else $error("stage two item lost while output stalled");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !p2_ready |-> !load)
      else $error("stage one overwritten while stalled");

endmodule

// ===== rtl/bbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bbe_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bbe_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pos
// input and output raster position, item filtering and edge masks
// ----------------------------------------------------------------------------
module bbe_pos (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       step,
   input  logic                       kind,
   input  logic [bbe_pkg::WID_W-1:0]  eff_w,
   input  logic [bbe_pkg::ROW_W-1:0]  eff_h,
   output bbe_pkg::ctl_type           ctl
);

   logic [bbe_pkg::COL_W-1:0]  in_col_ff,  in_col_in;
   logic [bbe_pkg::ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [bbe_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [bbe_pkg::OROW_W-1:0] out_row_ff, out_row_in;
   logic                       in_done;

   always_comb begin
      in_done      = in_row_ff >= eff_h;
      ctl.take     = (kind == bbe_pkg::KIND_PIXEL) ? !in_done : in_done;
      ctl.emit     = (in_row_ff >= bbe_pkg::ROW_W'(2))
                  || ((in_row_ff == bbe_pkg::ROW_W'(1)) && (in_col_ff != '0));
      ctl.top_ok   = out_row_ff != '0;
      ctl.bot_ok   = (bbe_pkg::ROW_W'(out_row_ff) + bbe_pkg::ROW_W'(1)) < eff_h;
      ctl.left_ok  = out_col_ff != '0;
      ctl.right_ok = (bbe_pkg::WID_W'(out_col_ff) + bbe_pkg::WID_W'(1)) < eff_w;
      ctl.last     = !ctl.bot_ok && !ctl.right_ok;
      ctl.col      = in_col_ff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (step && ctl.take) begin
         if ((bbe_pkg::WID_W'(in_col_ff) + bbe_pkg::WID_W'(1)) >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + bbe_pkg::ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + bbe_pkg::COL_W'(1);
         end
         if (ctl.emit) begin
            if (ctl.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if ((bbe_pkg::WID_W'(out_col_ff) + bbe_pkg::WID_W'(1)) >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + bbe_pkg::OROW_W'(1);
            end else begin
               out_col_in = out_col_ff + bbe_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule
